/* design/scsa_pkg.sv */
package scsa_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int POOL_BLOCKS = 256;
	localparam int CLASS_W     = $clog2(NUM_CLASSES);
	localparam int IDX_W       = $clog2(POOL_BLOCKS);
	localparam int LINK_W      = IDX_W + 1;
	localparam int ADDR_W      = CLASS_W + IDX_W;
	localparam int MEM_DEPTH   = NUM_CLASSES * POOL_BLOCKS;
	localparam int LIMIT_W     = 8;
	localparam int SIZE_W      = 16;
	localparam int HANDLE_W    = 10;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int CFG_INDEX_W = 3;

	typedef logic [CLASS_W-1:0]  class_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [LINK_W-1:0]   link_t;
	typedef logic [LIMIT_W-1:0]  limit_t;
	typedef logic [SIZE_W-1:0]   size_t;
	typedef limit_t [NUM_CLASSES-1:0] limits_t;
	typedef link_t  [NUM_CLASSES-1:0] heads_t;

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESIZE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SAME    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_GENERAL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;

	localparam limits_t LIMIT_RESET = {8'd128, 8'd96, 8'd64, 8'd48};

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		size_t               request_size;
		size_t               old_size;
		logic [HANDLE_W-1:0] handle_in;
		logic                handle_present;
	} cmd_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		logic [STATUS_W-1:0] status;
		size_t               copy_bytes;
		logic                old_to_general;
	} rsp_t;

	typedef struct packed {
		logic   pop;
		class_t pop_class;
		idx_t   pop_index;
		logic   push;
		class_t push_class;
		idx_t   push_index;
	} fl_op_t;

endpackage

/* design/size_class_slab_allocator_top.sv */
// Flow: a command word is registered into cmd_s1, then its response word into rsp_q; a held rsp_q stalls cmd_s1.
// Throughput: one command per cycle while rsp_ready holds, also back to back on one class,
//   as the pending pop's link read is forwarded as that class's head in the following cycle.
// Reset: limits return to 48/64/96/128 and all heads to index zero; a chaining pass then
//   writes all 1024 link-memory entries, one entry a cycle, with cmd_ready low.
module size_class_slab_allocator_top import scsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  cmd_t                   cmd,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output rsp_t                   rsp,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  limit_t                 cfg_data
);

	limits_t limits_q;
	cmd_t    cmd_s1;
	logic    cmd_valid_s1;
	rsp_t    rsp_q;
	logic    rsp_valid_q;
	logic    advance;
	logic    fl_ready;
	heads_t  heads;
	class_t  cn;
	class_t  co;
	logic    cn_hit;
	logic    co_hit;
	link_t   head_n;
	logic    avail;
	logic    is_alloc;
	logic    same;
	rsp_t    rsp_next;
	fl_op_t  op_raw;
	fl_op_t  op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				if (cfg_index == CFG_INDEX_W'(c)) begin
					limits_q[c] <= cfg_data;
				end
			end
		end
	end

	assign advance   = cmd_valid_s1 && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = fl_ready && (!cmd_valid_s1 || advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_valid && cmd_ready) begin
			cmd_valid_s1 <= 1'b1;
		end else if (advance) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	scsa_class_map u_map_new (
		.limits(limits_q),
		.size  (cmd_s1.request_size),
		.cls   (cn),
		.hit   (cn_hit)
	);

	scsa_class_map u_map_old (
		.limits(limits_q),
		.size  (cmd_s1.old_size),
		.cls   (co),
		.hit   (co_hit)
	);

	assign head_n   = heads[cn];
	assign avail    = !head_n[LINK_W-1];
	assign is_alloc = (cmd_s1.kind == KIND_ALLOC)
		|| (cmd_s1.kind == KIND_RESIZE && !cmd_s1.handle_present);
	assign same     = (cmd_s1.request_size == cmd_s1.old_size)
		|| (cn_hit && co_hit && cn == co);

	always_comb begin
		rsp_next            = '0;
		rsp_next.status     = ST_DONE;
		op_raw              = '0;
		op_raw.pop_class    = cn;
		op_raw.pop_index    = head_n[IDX_W-1:0];
		op_raw.push_class   = co;
		op_raw.push_index   = cmd_s1.handle_in[IDX_W-1:0];
		if (is_alloc) begin
			if (!cn_hit) begin
				rsp_next.status = ST_GENERAL;
			end else if (avail) begin
				op_raw.pop          = 1'b1;
				rsp_next.status     = ST_NEW;
				rsp_next.handle_out = {cn, head_n[IDX_W-1:0]};
			end else begin
				rsp_next.status = ST_EMPTY;
			end
		end else if (cmd_s1.kind == KIND_RELEASE) begin
			if (cmd_s1.handle_present) begin
				if (!cn_hit) begin
					rsp_next.old_to_general = 1'b1;
				end else begin
					op_raw.push       = 1'b1;
					op_raw.push_class = cn;
				end
			end
		end else if (cmd_s1.kind == KIND_RESIZE) begin
			if (same) begin
				rsp_next.status     = ST_SAME;
				rsp_next.handle_out = cmd_s1.handle_in;
			end else if (cn_hit) begin
				if (avail) begin
					op_raw.pop          = 1'b1;
					rsp_next.status     = ST_NEW;
					rsp_next.handle_out = {cn, head_n[IDX_W-1:0]};
					rsp_next.copy_bytes = (cmd_s1.old_size < cmd_s1.request_size)
						? cmd_s1.old_size : cmd_s1.request_size;
					if (!co_hit) begin
						rsp_next.old_to_general = 1'b1;
					end else begin
						op_raw.push = 1'b1;
					end
				end else begin
					rsp_next.status = ST_EMPTY;
				end
			end else begin
				rsp_next.status = ST_GENERAL;
				if (!co_hit) begin
					rsp_next.old_to_general = 1'b1;
				end else begin
					rsp_next.copy_bytes = cmd_s1.old_size;
					op_raw.push         = 1'b1;
				end
			end
		end
	end

	always_comb begin
		op      = op_raw;
		op.pop  = op_raw.pop && advance;
		op.push = op_raw.push && advance;
	end

	scsa_free_list u_free_list (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (op),
		.heads (heads),
		.ready (fl_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == ST_EMPTY
		|-> rsp_q.handle_out == '0 && rsp_q.copy_bytes == '0 && !rsp_q.old_to_general)
		else $error("pool-empty word carries a handle or copy");

	a_same_no_copy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == ST_SAME
		|-> rsp_q.copy_bytes == '0 && !rsp_q.old_to_general)
		else $error("unchanged handle with copy or general free");

endmodule

/* design/scsa_ram.sv */
module scsa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/scsa_class_map.sv */
module scsa_class_map import scsa_pkg::*; (
	input  limits_t limits,
	input  size_t   size,
	output class_t  cls,
	output logic    hit
);

	always_comb begin
		hit = 1'b0;
		cls = '0;
		// scan downwards so the lowest matching class wins
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (size <= SIZE_W'(limits[c])) begin
				hit = 1'b1;
				cls = class_t'(c);
			end
		end
	end

endmodule

/* design/scsa_free_list.sv */
module scsa_free_list import scsa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  fl_op_t op,
	output heads_t heads,
	output logic   ready
);

	logic [ADDR_W-1:0] clr_cnt_q;
	logic              clear_done_q;
	logic              pend_q;
	class_t            pend_class_q;
	heads_t            heads_q;
	heads_t            heads_next;
	link_t             rdata;
	link_t             clr_link;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	link_t             wdata;

	// chain each pool in index order; the last entry wraps to null
	assign clr_link = {1'b0, clr_cnt_q[IDX_W-1:0]} + LINK_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			clear_done_q <= 1'b0;
		end else if (!clear_done_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == ADDR_W'(MEM_DEPTH - 1)) begin
				clear_done_q <= 1'b1;
			end
		end
	end

	// forward the link read of last cycle's pop as that class's head
	always_comb begin
		heads = heads_q;
		if (pend_q) begin
			heads[pend_class_q] = rdata;
		end
	end

	always_comb begin
		heads_next = heads;
		if (op.push) begin
			heads_next[op.push_class] = {1'b0, op.push_index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heads_q      <= '0;
			pend_q       <= 1'b0;
			pend_class_q <= '0;
		end else begin
			heads_q      <= heads_next;
			pend_q       <= op.pop;
			pend_class_q <= op.pop_class;
		end
	end

	assign we    = !clear_done_q || op.push;
	assign waddr = clear_done_q ? {op.push_class, op.push_index} : clr_cnt_q;
	assign wdata = clear_done_q ? heads[op.push_class] : clr_link;

	scsa_ram #(
		.WIDTH(LINK_W),
		.DEPTH(MEM_DEPTH)
	) u_links (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (op.pop),
		.raddr({op.pop_class, op.pop_index}),
		.rdata(rdata)
	);

	assign ready = clear_done_q;

	a_pop_push_split: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop && op.push |-> op.pop_class != op.push_class)
		else $error("pop and push hit one class in a cycle");

	a_idle_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_done_q |-> !op.pop && !op.push)
		else $error("free list touched during chaining pass");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop |-> !heads[op.pop_class][LINK_W-1])
		else $error("pop from an empty pool");

endmodule
